[rtl/bcd_datetime_to_epoch_seconds_unit_macros.svh]
// Assertion macros shared by the date and time conversion unit.
`ifndef BCD_DATETIME_TO_EPOCH_SECONDS_UNIT_MACROS_SVH
`define BCD_DATETIME_TO_EPOCH_SECONDS_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BDTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BDTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bdte_pkg.sv]
// Types, constants and the month table of the date and time conversion unit.
package bdte_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 7;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned HMS_W   = 19;
    localparam int unsigned EPOCH_W = 32;

    localparam logic [16:0] SECS_PER_DAY     = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN     = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
    localparam logic [5:0]  YEARS_1970_2000  = 6'd30;
    localparam logic [2:0]  LEAPS_1970_2000  = 3'd7;
    localparam logic [3:0]  BCD_MAX_DIGIT    = 4'd9;
    localparam logic [6:0]  MONTHS           = 7'd12;

    // Decoded reading, one binary value per field.
    typedef struct packed {
        logic               err;
        logic [VALUE_W-1:0] second;
        logic [VALUE_W-1:0] minute;
        logic [VALUE_W-1:0] hour;
        logic [VALUE_W-1:0] day;
        logic [VALUE_W-1:0] month;
        logic [VALUE_W-1:0] year;
    } bdte_fields_t;

    // Whole days since the epoch and the seconds within the day.
    typedef struct packed {
        logic              err;
        logic [DAYS_W-1:0] days;
        logic [HMS_W-1:0]  hms;
    } bdte_partial_t;

    // Days in the year before the first of the given month (0 = January).
    function automatic logic [8:0] month_start_days(input logic [3:0] idx);
        logic [8:0] d;
        unique case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

[rtl/bdte_bcd_decode.sv]
// Checks the six packed BCD bytes and turns them into binary values.
module bdte_bcd_decode (
    input  logic [7:0]            bcd_second,
    input  logic [7:0]            bcd_minute,
    input  logic [7:0]            bcd_hour,
    input  logic [7:0]            bcd_day,
    input  logic [7:0]            bcd_month,
    input  logic [7:0]            bcd_year,
    output bdte_pkg::bdte_fields_t fields
);
    import bdte_pkg::*;

    function automatic logic bcd_ok(input logic [BYTE_W-1:0] b);
        return (b[3:0] <= BCD_MAX_DIGIT) && (b[7:4] <= BCD_MAX_DIGIT);
    endfunction

    function automatic logic [VALUE_W-1:0] bcd_value(input logic [BYTE_W-1:0] b);
        // Tens times ten is tens times eight plus tens times two.
        return VALUE_W'({3'b000, b[3:0]}) + VALUE_W'({b[7:4], 3'b000})
             + VALUE_W'({2'b00, b[7:4], 1'b0});
    endfunction

    logic digits_ok;

    always_comb begin
        digits_ok = bcd_ok(bcd_second) && bcd_ok(bcd_minute) && bcd_ok(bcd_hour)
                 && bcd_ok(bcd_day) && bcd_ok(bcd_month) && bcd_ok(bcd_year);
        fields.second = bcd_value(bcd_second);
        fields.minute = bcd_value(bcd_minute);
        fields.hour   = bcd_value(bcd_hour);
        fields.day    = bcd_value(bcd_day);
        fields.month  = bcd_value(bcd_month);
        fields.year   = bcd_value(bcd_year);
        fields.err    = !digits_ok || (fields.month == '0) || (fields.month > MONTHS)
                     || (fields.day == '0);
    end

endmodule

[rtl/bdte_day_count.sv]
// Counts whole days since the epoch and the seconds elapsed within the day.
module bdte_day_count (
    input  bdte_pkg::bdte_fields_t  fields,
    output bdte_pkg::bdte_partial_t partial
);
    import bdte_pkg::*;

    logic [DAYS_W-1:0] year_days;
    logic [DAYS_W-1:0] leap_days;
    logic              leap_this_year;
    logic [3:0]        month_idx;
    logic [DAYS_W-1:0] days;
    logic [HMS_W-1:0]  hms;

    always_comb begin
        year_days = DAYS_W'(DAYS_W'(DAYS_PER_YEAR)
                  * (DAYS_W'(fields.year) + DAYS_W'(YEARS_1970_2000)));
        // Leap years from 2000 up to the year before the current one.
        leap_days = DAYS_W'(LEAPS_1970_2000)
                  + DAYS_W'((VALUE_W'(fields.year) + VALUE_W'(3)) >> 2);
        // The current year's leap day only counts once February is over.
        leap_this_year = (fields.year[1:0] == 2'b00) && (fields.month > VALUE_W'(2));
        month_idx = 4'(fields.month - VALUE_W'(1));
        days = year_days + leap_days + DAYS_W'(leap_this_year)
             + DAYS_W'(month_start_days(month_idx))
             + DAYS_W'(fields.day) - DAYS_W'(1);
        hms = HMS_W'(HMS_W'(fields.hour) * HMS_W'(SECS_PER_HOUR))
            + HMS_W'(HMS_W'(fields.minute) * HMS_W'(SECS_PER_MIN))
            + HMS_W'(fields.second);

        partial.err  = fields.err;
        partial.days = fields.err ? '0 : days;
        partial.hms  = fields.err ? '0 : hms;
    end

endmodule

[rtl/bdte_scale.sv]
// Scales whole days to seconds and adds the seconds within the day.
module bdte_scale (
    input  bdte_pkg::bdte_partial_t partial,
    output logic [31:0]             epoch_seconds
);
    import bdte_pkg::*;

    // An error has already cleared days and seconds, so the sum is zero.
    assign epoch_seconds = EPOCH_W'(EPOCH_W'(partial.days) * EPOCH_W'(SECS_PER_DAY))
                         + EPOCH_W'(partial.hms);

endmodule

[rtl/bcd_datetime_to_epoch_seconds_unit.sv]
// Converts a BCD clock reading (2000 to 2099) into seconds since 1970-01-01 00:00:00.
//
// Input channel s_: one word per reading, six packed BCD bytes (second, minute,
// hour, day, month, two-digit year), taken when s_valid and s_ready are high.
// Result channel m_: one word per reading, m_epoch_seconds and m_field_error,
// taken when m_valid and m_ready are high. A bad BCD digit, a month outside
// 1 to 12 or a day of zero gives m_field_error high and a zero count.
//
// The word passes an input register, a register holding day count and
// seconds within the day, and the result register, in that order. One word
// is taken in every cycle while the result channel does not stall; the day to
// seconds multiplication sits alone between the middle and result registers.
//
// Each stage takes a new word whenever it is empty or its word moves on, so
// a stalled receiver fills the three stages before s_ready falls, and words
// held in the stages wait unchanged until m_ready returns.
// A synchronous reset (aresetn low) empties all three stages at once.
module bcd_datetime_to_epoch_seconds_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_bcd_second,
    input  logic [7:0]  s_bcd_minute,
    input  logic [7:0]  s_bcd_hour,
    input  logic [7:0]  s_bcd_day,
    input  logic [7:0]  s_bcd_month,
    input  logic [7:0]  s_bcd_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_epoch_seconds,
    output logic        m_field_error
);
    import bdte_pkg::*;

    `include "bcd_datetime_to_epoch_seconds_unit_macros.svh"

    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    second_reg, minute_reg, hour_reg, day_reg, month_reg, year_reg;
    logic                 mid_valid_reg;
    bdte_partial_t        mid_reg;
    logic                 out_valid_reg;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic                 error_reg;

    bdte_fields_t         fields;
    bdte_partial_t        mid_next;
    logic [EPOCH_W-1:0]   epoch_next;

    logic                 out_ready;
    logic                 mid_ready;

    assign out_ready = !out_valid_reg || m_ready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign s_ready   = !in_valid_reg || mid_ready;

    bdte_bcd_decode u_decode (
        .bcd_second (second_reg),
        .bcd_minute (minute_reg),
        .bcd_hour   (hour_reg),
        .bcd_day    (day_reg),
        .bcd_month  (month_reg),
        .bcd_year   (year_reg),
        .fields     (fields)
    );

    bdte_day_count u_day_count (
        .fields  (fields),
        .partial (mid_next)
    );

    bdte_scale u_scale (
        .partial       (mid_reg),
        .epoch_seconds (epoch_next)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            second_reg <= s_bcd_second;
            minute_reg <= s_bcd_minute;
            hour_reg   <= s_bcd_hour;
            day_reg    <= s_bcd_day;
            month_reg  <= s_bcd_month;
            year_reg   <= s_bcd_year;
        end
    end

    // Day count and seconds within the day.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (mid_ready) begin
            mid_valid_reg <= in_valid_reg;
        end
        if (in_valid_reg && mid_ready) begin
            mid_reg <= mid_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= mid_valid_reg;
        end
        if (mid_valid_reg && out_ready) begin
            epoch_reg <= epoch_next;
            error_reg <= mid_reg.err;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_epoch_seconds = epoch_reg;
    assign m_field_error   = error_reg;

    `BDTE_ASSERT_SAME(a_error_gives_zero, aclk, aresetn, m_valid && m_field_error, m_epoch_seconds == '0, "flagged word carries a non-zero count")
    `BDTE_ASSERT_NEXT(a_input_loads, aclk, aresetn, s_valid && s_ready, in_valid_reg, "accepted word missing from input register")
    `BDTE_ASSERT_NEXT(a_mid_advances, aclk, aresetn, mid_valid_reg && out_ready, m_valid, "middle stage word lost on its way to the result register")
    `BDTE_ASSERT_NEXT(a_input_holds, aclk, aresetn, in_valid_reg && !mid_ready, in_valid_reg && $stable(day_reg) && $stable(month_reg), "stalled input register changed")

endmodule

[test/bcd_epoch_checker.sv]
`timescale 1ns / 100ps
// Watches both channels of the BCD date and time unit, predicts each result and compares it.
module bcd_epoch_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_bcd_second,
    input  logic [7:0]  s_bcd_minute,
    input  logic [7:0]  s_bcd_hour,
    input  logic [7:0]  s_bcd_day,
    input  logic [7:0]  s_bcd_month,
    input  logic [7:0]  s_bcd_year,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_epoch_seconds,
    input  logic        m_field_error,
    output int          fail_count,
    output int          outstanding,
    output int          results_checked,
    output int          flagged_results
);

    localparam int unsigned SECONDS_PER_DAY   = 86400;
    localparam int unsigned SECONDS_PER_HOUR  = 3600;
    localparam int unsigned SECONDS_PER_MIN   = 60;
    localparam int unsigned DAYS_IN_YEAR      = 365;
    localparam int unsigned YEARS_BEFORE_2000 = 30;
    localparam int unsigned LEAP_DAYS_TO_2000 = 7;
    localparam int unsigned MONTHS_IN_YEAR    = 12;
    localparam int unsigned MAX_DIGIT         = 9;

    typedef struct packed {
        logic [47:0] reading;
        logic        flagged;
        logic [31:0] seconds;
    } epoch_expectation_t;

    epoch_expectation_t expected_q[$];
    int mismatches = 0;
    int checked    = 0;
    int flagged    = 0;

    function automatic int unsigned bcd_value(input logic [7:0] b);
        return 10 * b[7:4] + b[3:0];
    endfunction

    function automatic int unsigned days_before_month(input int unsigned month);
        int unsigned d;
        case (month)
            1:       d = 0;
            2:       d = 31;
            3:       d = 59;
            4:       d = 90;
            5:       d = 120;
            6:       d = 151;
            7:       d = 181;
            8:       d = 212;
            9:       d = 243;
            10:      d = 273;
            11:      d = 304;
            default: d = 334;
        endcase
        return d;
    endfunction

    function automatic epoch_expectation_t predict_epoch(input logic [7:0] sc_b, mn_b, hr_b,
                                                          dy_b, mo_b, yr_b);
        epoch_expectation_t r;
        int unsigned        sc, mn, hr, dy, mo, yr, leap_days, day_count;
        longint unsigned    total;
        r.reading = {yr_b, mo_b, dy_b, hr_b, mn_b, sc_b};
        r.flagged = 1'b0;
        r.seconds = '0;
        for (int i = 0; i < 12; i++) begin
            if (r.reading[4*i +: 4] > MAX_DIGIT) r.flagged = 1'b1;
        end
        sc = bcd_value(sc_b);
        mn = bcd_value(mn_b);
        hr = bcd_value(hr_b);
        dy = bcd_value(dy_b);
        mo = bcd_value(mo_b);
        yr = bcd_value(yr_b);
        if (mo < 1 || mo > MONTHS_IN_YEAR || dy == 0) r.flagged = 1'b1;
        if (!r.flagged) begin
            // The leap day of the current year only counts once February is over.
            leap_days = LEAP_DAYS_TO_2000 + (yr + 3) / 4;
            if (yr % 4 == 0 && mo > 2) leap_days++;
            day_count = DAYS_IN_YEAR * (yr + YEARS_BEFORE_2000) + leap_days
                      + days_before_month(mo) + dy - 1;
            total = longint'(day_count) * SECONDS_PER_DAY + hr * SECONDS_PER_HOUR
                  + mn * SECONDS_PER_MIN + sc;
            r.seconds = total[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t MISMATCH %s", $time, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        epoch_expectation_t oldest;
        if (!aresetn) begin
            expected_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                expected_q.push_back(predict_epoch(s_bcd_second, s_bcd_minute, s_bcd_hour,
                                                   s_bcd_day, s_bcd_month, s_bcd_year));
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d error=%0b with no word outstanding",
                                              m_epoch_seconds, m_field_error));
                end else begin
                    oldest = expected_q.pop_front();
                    checked++;
                    if (oldest.flagged) flagged++;
                    if (m_field_error !== oldest.flagged) begin
                        report_mismatch($sformatf(
                            "20%h-%h-%h %h:%h:%h error flag %0b, expected %0b",
                            oldest.reading[47:40], oldest.reading[39:32], oldest.reading[31:24],
                            oldest.reading[23:16], oldest.reading[15:8], oldest.reading[7:0],
                            m_field_error, oldest.flagged));
                    end
                    if (m_epoch_seconds !== oldest.seconds) begin
                        report_mismatch($sformatf(
                            "20%h-%h-%h %h:%h:%h seconds %0d, expected %0d",
                            oldest.reading[47:40], oldest.reading[39:32], oldest.reading[31:24],
                            oldest.reading[23:16], oldest.reading[15:8], oldest.reading[7:0],
                            m_epoch_seconds, oldest.seconds));
                    end
                end
            end
        end
        fail_count      <= mismatches;
        outstanding     <= expected_q.size();
        results_checked <= checked;
        flagged_results <= flagged;
    end

endmodule

[test/tb_bcd_datetime_to_epoch_seconds_unit.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the BCD date and time to epoch seconds unit.
module tb_bcd_datetime_to_epoch_seconds_unit;

    localparam int RANDOM_WORDS = 1550;
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 650;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_PERCENT = 21;
    localparam int DRAIN_CYCLES = 12;

    typedef enum logic [1:0] {
        READING_CALENDAR,
        READING_OVERSIZED,
        READING_RAW
    } reading_kind_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic [7:0]  s_bcd_second  = '0;
    logic [7:0]  s_bcd_minute  = '0;
    logic [7:0]  s_bcd_hour    = '0;
    logic [7:0]  s_bcd_day     = '0;
    logic [7:0]  s_bcd_month   = '0;
    logic [7:0]  s_bcd_year    = '0;
    logic        m_ready       = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [31:0] m_epoch_seconds;
    logic        m_field_error;

    int   words_sent    = 0;
    logic quiet_stretch = 1'b0;
    logic hold_done     = 1'b0;
    int   fail_count;
    int   outstanding;
    int   results_checked;
    int   flagged_results;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    bcd_datetime_to_epoch_seconds_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_bcd_second    (s_bcd_second),
        .s_bcd_minute    (s_bcd_minute),
        .s_bcd_hour      (s_bcd_hour),
        .s_bcd_day       (s_bcd_day),
        .s_bcd_month     (s_bcd_month),
        .s_bcd_year      (s_bcd_year),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_epoch_seconds (m_epoch_seconds),
        .m_field_error   (m_field_error)
    );

    bcd_epoch_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_bcd_second    (s_bcd_second),
        .s_bcd_minute    (s_bcd_minute),
        .s_bcd_hour      (s_bcd_hour),
        .s_bcd_day       (s_bcd_day),
        .s_bcd_month     (s_bcd_month),
        .s_bcd_year      (s_bcd_year),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_epoch_seconds (m_epoch_seconds),
        .m_field_error   (m_field_error),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .flagged_results (flagged_results)
    );

    function automatic logic [7:0] to_bcd(input int unsigned v);
        logic [7:0] b;
        b[7:4] = 4'(v / 10);
        b[3:0] = 4'(v % 10);
        return b;
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic send_word(input logic [7:0] sc, mn, hr, dy, mo, yr);
        while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_bcd_second <= sc;
        s_bcd_minute <= mn;
        s_bcd_hour   <= hr;
        s_bcd_day    <= dy;
        s_bcd_month  <= mo;
        s_bcd_year   <= yr;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    task automatic send_random_reading();
        reading_kind_t kind;
        int unsigned   pick;
        pick = $urandom_range(99);
        kind = (pick < 70) ? READING_CALENDAR :
               (pick < 85) ? READING_OVERSIZED : READING_RAW;
        case (kind)
            READING_CALENDAR: begin
                send_word(to_bcd($urandom_range(59)), to_bcd($urandom_range(59)),
                          to_bcd($urandom_range(23)), to_bcd($urandom_range(31, 1)),
                          to_bcd($urandom_range(12, 1)), to_bcd($urandom_range(99)));
            end
            READING_OVERSIZED: begin
                send_word(to_bcd($urandom_range(99)), to_bcd($urandom_range(99)),
                          to_bcd($urandom_range(99)), to_bcd($urandom_range(99)),
                          to_bcd($urandom_range(13)), to_bcd($urandom_range(99)));
            end
            default: begin
                send_word(8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
            end
        endcase
    endtask

    // Receiver: random back-pressure, plus one long hold-off that fills the pipeline.
    initial begin
        forever begin
            @(posedge aclk);
            if (!hold_done && words_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= !(!quiet_stretch && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Corner dates and leap-year boundaries.
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);
        send_word(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);
        send_word(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h00);
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00);
        send_word(8'h59, 8'h59, 8'h23, 8'h31, 8'h01, 8'h16);
        send_word(8'h30, 8'h15, 8'h12, 8'h29, 8'h02, 8'h16);
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h16);
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01);
        send_word(8'h45, 8'h30, 8'h09, 8'h15, 8'h10, 8'h24);
        send_word(8'h01, 8'h02, 8'h03, 8'h30, 8'h11, 8'h98);
        // Digits that are valid BCD but beyond the calendar range.
        send_word(8'h99, 8'h99, 8'h99, 8'h99, 8'h12, 8'h99);
        // A non-BCD digit in each field in turn.
        send_word(8'h5A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);
        send_word(8'h00, 8'hA0, 8'h00, 8'h01, 8'h01, 8'h00);
        send_word(8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h00);
        send_word(8'h00, 8'h00, 8'h00, 8'h3B, 8'h01, 8'h00);
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 8'h1F, 8'h00);
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hF9);
        // Month out of range and day zero.
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h20);
        send_word(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h20);
        send_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h06, 8'h20);
        send_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet_stretch = (n >= QUIET_FROM && n < QUIET_TO);
            send_random_reading();
        end
        quiet_stretch = 1'b0;
        s_valid <= 1'b0;

        // The checker's count is registered, so let it take in the last word first.
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words: corner dates, leap days, bad digits and random readings.",
                 words_sent);
        $display("Checked %0d results, %0d of them flagged as bad readings.",
                 results_checked, flagged_results);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("Timed out with %0d words sent.", words_sent);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
